// ===== src/window_weighted_square_count_sum_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the window power block
// Concurrent assertion wrappers that can be compiled out with ASSERT_OFF.
// ----------------------------------------------------------------------------
`ifndef WINDOW_WEIGHTED_SQUARE_COUNT_SUM_MACROS_SVH
`define WINDOW_WEIGHTED_SQUARE_COUNT_SUM_MACROS_SVH
`ifndef ASSERT_OFF
`define WWSC_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define WWSC_ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define WWSC_ASSERT(label, clk, rst, prop, msg)
`define WWSC_ASSERT_NEVER(label, clk, rst, cond, msg)
`endif
`endif

// ===== src/wwsc_pkg.sv =====
// ----------------------------------------------------------------------------
// Window power package
// Shared types, codes and constants of the window power block.
// ----------------------------------------------------------------------------
`default_nettype none

package wwsc_pkg;

   localparam int FIELD_W          = 10;
   localparam int POWER_W          = 30;
   localparam int DEF_MAX_ELEMENTS = 1024;
   localparam int DEF_VALUE_RANGE  = 1024;
   localparam int QUEUE_DEPTH      = 2;

   localparam logic [POWER_W-1:0] POWER_MAX = {POWER_W{1'b1}};

   localparam logic CMD_LOAD  = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   typedef struct packed {
      logic               cmd;
      logic [FIELD_W-1:0] position;
      logic [FIELD_W-1:0] right_end;
      logic [FIELD_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic [POWER_W-1:0] power;
      logic               status;
   } rsp_type;

   typedef enum logic [1:0] {
      JOB_LOAD,
      JOB_QUERY,
      JOB_REJECT
   } job_kind_type;

   typedef struct packed {
      job_kind_type       kind;
      logic [FIELD_W-1:0] left_idx;
      logic [FIELD_W-1:0] right_idx;
      logic [FIELD_W-1:0] value;
   } job_type;

   typedef struct packed {
      logic    valid;
      job_type job;
   } queue_out_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_WALK,
      ST_ERD,
      ST_EVAL,
      ST_HRD,
      ST_HUPD,
      ST_ACC
   } back_state_type;

endpackage

`default_nettype wire

// ===== src/wwsc_front.sv =====
// ----------------------------------------------------------------------------
// Window power request front end
// Accepts requests, clamps indexes and values and classifies each request.
// ----------------------------------------------------------------------------
`default_nettype none

module wwsc_front
   import wwsc_pkg::*;
#(
   parameter int MAX_ELEMENTS = DEF_MAX_ELEMENTS,
   parameter int VALUE_RANGE  = DEF_VALUE_RANGE
) (
   input  wire logic    start,
   input  wire req_type req_data,
   input  wire logic    q_full,
   input  wire logic    clearing,
   output logic         busy,
   output logic         push,
   output job_type      job
);

   localparam int FieldTop = (1 << FIELD_W) - 1;
   localparam int IdxTop   = (MAX_ELEMENTS - 1 < FieldTop) ? MAX_ELEMENTS - 1 : FieldTop;
   localparam int ValTop   = (VALUE_RANGE - 1 < FieldTop) ? VALUE_RANGE - 1 : FieldTop;

   logic               pos_big;
   logic               rgt_big;
   logic [FIELD_W-1:0] left_c;
   logic [FIELD_W-1:0] right_c;
   logic [FIELD_W-1:0] value_c;

   always_comb begin
      pos_big = req_data.position > FIELD_W'(IdxTop);
      rgt_big = req_data.right_end > FIELD_W'(IdxTop);
      left_c  = pos_big ? FIELD_W'(IdxTop) : req_data.position;
      right_c = rgt_big ? FIELD_W'(IdxTop) : req_data.right_end;
      value_c = (req_data.value > FIELD_W'(ValTop)) ? FIELD_W'(ValTop) : req_data.value;

      busy = q_full || clearing;

      job.left_idx  = left_c;
      job.right_idx = right_c;
      job.value     = value_c;
      if (req_data.cmd == CMD_LOAD) begin
         job.kind = JOB_LOAD;
      end else if (left_c > right_c) begin
         job.kind = JOB_REJECT;
      end else begin
         job.kind = JOB_QUERY;
      end

      // A load beyond the element store is dropped here.
      push = start && !busy && !(req_data.cmd == CMD_LOAD && pos_big);
   end

endmodule

`default_nettype wire

// ===== src/wwsc_queue.sv =====
// ----------------------------------------------------------------------------
// Window power job queue
// Short FIFO of classified requests between the front end and the engine.
// ----------------------------------------------------------------------------
`default_nettype none

module wwsc_queue
   import wwsc_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire job_type job_in,
   input  wire logic    pop,
   output queue_out_type q_out,
   output logic         q_full
);

   localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CntW = $clog2(QUEUE_DEPTH + 1);

   job_type             entries_ff [QUEUE_DEPTH];
   logic [PtrW-1:0]     wr_ptr_ff;
   logic [PtrW-1:0]     wr_ptr_in;
   logic [PtrW-1:0]     rd_ptr_ff;
   logic [PtrW-1:0]     rd_ptr_in;
   logic [CntW-1:0]     count_ff;
   logic [CntW-1:0]     count_in;

   function automatic logic [PtrW-1:0] next_ptr(input logic [PtrW-1:0] ptr);
      logic [PtrW-1:0] nxt;
      if (ptr == PtrW'(QUEUE_DEPTH - 1)) begin
         nxt = '0;
      end else begin
         nxt = ptr + PtrW'(1);
      end
      return nxt;
   endfunction

   always_comb begin
      wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CntW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CntW'(1);
      end
      q_full      = count_ff == CntW'(QUEUE_DEPTH);
      q_out.valid = count_ff != '0;
      q_out.job   = entries_ff[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= job_in;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

// ===== src/wwsc_back.sv =====
// ----------------------------------------------------------------------------
// Window power engine
// Holds the element store and the value histogram and moves the window one
// element per step, keeping the running power sum.
// ----------------------------------------------------------------------------
`default_nettype none

module wwsc_back
   import wwsc_pkg::*;
#(
   parameter int MAX_ELEMENTS = DEF_MAX_ELEMENTS,
   parameter int VALUE_RANGE  = DEF_VALUE_RANGE
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire queue_out_type q_out,
   output logic               pop,
   output logic               rsp_valid,
   output rsp_type            rsp_data,
   output logic               clearing
);

   localparam int IW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
   localparam int VW = $clog2(VALUE_RANGE);
   localparam int CW = $clog2(MAX_ELEMENTS + 1);
   localparam int SW = VW + 2 * CW;
   localparam int PW = VW + CW + 1;

   logic [VW-1:0] elem_mem [MAX_ELEMENTS];
   logic [CW-1:0] hist_mem [VALUE_RANGE];

   back_state_type state_ff, state_in;
   logic [IW-1:0]  wl_ff, wl_in;
   logic [IW-1:0]  wr_ff, wr_in;
   logic           empty_ff, empty_in;
   logic [SW-1:0]  sum_ff, sum_in;
   logic [IW-1:0]  ql_ff, ql_in;
   logic [IW-1:0]  qr_ff, qr_in;
   logic [IW-1:0]  addr_ff, addr_in;
   logic [VW-1:0]  v_ff, v_in;
   logic [VW-1:0]  load_v_ff, load_v_in;
   logic           enter_ff, enter_in;
   logic           query_ff, query_in;
   logic           phase_ff, phase_in;
   logic [PW-1:0]  prod_ff, prod_in;
   logic [VW-1:0]  clr_ff, clr_in;
   logic [VW-1:0]  elem_q_ff;
   logic [CW-1:0]  hist_q_ff;
   logic           rsp_valid_ff, rsp_valid_in;
   rsp_type        rsp_data_ff, rsp_data_in;

   logic           elem_we;
   logic [IW-1:0]  elem_waddr;
   logic [VW-1:0]  elem_wdata;
   logic           hist_we;
   logic [VW-1:0]  hist_waddr;
   logic [CW-1:0]  hist_wdata;
   logic [CW:0]    factor;
   logic           step_done;
   logic [IW-1:0]  job_pos;
   logic [VW-1:0]  job_val;

   always_comb begin
      state_in     = state_ff;
      wl_in        = wl_ff;
      wr_in        = wr_ff;
      empty_in     = empty_ff;
      sum_in       = sum_ff;
      ql_in        = ql_ff;
      qr_in        = qr_ff;
      addr_in      = addr_ff;
      v_in         = v_ff;
      load_v_in    = load_v_ff;
      enter_in     = enter_ff;
      query_in     = query_ff;
      phase_in     = phase_ff;
      prod_in      = prod_ff;
      clr_in       = clr_ff;
      rsp_valid_in = 1'b0;
      rsp_data_in  = rsp_data_ff;
      pop          = 1'b0;
      elem_we      = 1'b0;
      elem_waddr   = addr_ff;
      elem_wdata   = load_v_ff;
      hist_we      = 1'b0;
      hist_waddr   = v_ff;
      hist_wdata   = '0;
      factor       = '0;
      step_done    = 1'b0;
      job_pos      = IW'(q_out.job.left_idx);
      job_val      = VW'(q_out.job.value);

      unique case (state_ff)
         ST_CLEAR: begin
            hist_we    = 1'b1;
            hist_waddr = clr_ff;
            if (clr_ff == VW'(VALUE_RANGE - 1)) begin
               state_in = ST_IDLE;
            end else begin
               clr_in = clr_ff + VW'(1);
            end
         end
         ST_IDLE: begin
            if (q_out.valid) begin
               pop = 1'b1;
               unique case (q_out.job.kind)
                  JOB_REJECT: begin
                     rsp_valid_in       = 1'b1;
                     rsp_data_in.power  = '0;
                     rsp_data_in.status = 1'b1;
                  end
                  JOB_LOAD: begin
                     if (!empty_ff && job_pos >= wl_ff && job_pos <= wr_ff) begin
                        addr_in   = job_pos;
                        load_v_in = job_val;
                        enter_in  = 1'b0;
                        query_in  = 1'b0;
                        phase_in  = 1'b0;
                        state_in  = ST_ERD;
                     end else begin
                        elem_we    = 1'b1;
                        elem_waddr = job_pos;
                        elem_wdata = job_val;
                     end
                  end
                  JOB_QUERY: begin
                     ql_in    = job_pos;
                     qr_in    = IW'(q_out.job.right_idx);
                     query_in = 1'b1;
                     state_in = ST_WALK;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_WALK: begin
            priority if (empty_ff) begin
               wl_in    = ql_ff;
               wr_in    = ql_ff;
               empty_in = 1'b0;
               addr_in  = ql_ff;
               enter_in = 1'b1;
               state_in = ST_ERD;
            end else if (wl_ff > ql_ff) begin
               wl_in    = wl_ff - IW'(1);
               addr_in  = wl_ff - IW'(1);
               enter_in = 1'b1;
               state_in = ST_ERD;
            end else if (wr_ff < qr_ff) begin
               wr_in    = wr_ff + IW'(1);
               addr_in  = wr_ff + IW'(1);
               enter_in = 1'b1;
               state_in = ST_ERD;
            end else if (wl_ff < ql_ff) begin
               addr_in  = wl_ff;
               wl_in    = wl_ff + IW'(1);
               enter_in = 1'b0;
               state_in = ST_ERD;
            end else if (wr_ff > qr_ff) begin
               addr_in  = wr_ff;
               wr_in    = wr_ff - IW'(1);
               enter_in = 1'b0;
               state_in = ST_ERD;
            end else begin
               rsp_valid_in       = 1'b1;
               rsp_data_in.power  = (64'(sum_ff) > 64'(POWER_MAX)) ? POWER_MAX
                                                                   : POWER_W'(sum_ff);
               rsp_data_in.status = 1'b0;
               state_in           = ST_IDLE;
            end
         end
         ST_ERD: begin
            state_in = ST_EVAL;
         end
         ST_EVAL: begin
            v_in     = elem_q_ff;
            state_in = ST_HRD;
         end
         ST_HRD: begin
            state_in = ST_HUPD;
         end
         ST_HUPD: begin
            if (enter_ff) begin
               hist_we    = 1'b1;
               hist_wdata = hist_q_ff + CW'(1);
               factor     = {hist_q_ff, 1'b1};
               prod_in    = PW'(v_ff) * PW'(factor);
               state_in   = ST_ACC;
            end else if (hist_q_ff == '0) begin
               step_done = 1'b1;
            end else begin
               hist_we    = 1'b1;
               hist_wdata = hist_q_ff - CW'(1);
               factor     = {hist_q_ff, 1'b0} - (CW + 1)'(1);
               prod_in    = PW'(v_ff) * PW'(factor);
               state_in   = ST_ACC;
            end
         end
         ST_ACC: begin
            sum_in    = enter_ff ? sum_ff + SW'(prod_ff) : sum_ff - SW'(prod_ff);
            step_done = 1'b1;
         end
      endcase

      // A load into the window first removes the old element, then adds the
      // new value, and only then rewrites the element store.
      if (step_done) begin
         if (query_ff) begin
            state_in = ST_WALK;
         end else if (!phase_ff) begin
            phase_in = 1'b1;
            enter_in = 1'b1;
            v_in     = load_v_ff;
            state_in = ST_HRD;
         end else begin
            elem_we  = 1'b1;
            state_in = ST_IDLE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (elem_we) begin
         elem_mem[elem_waddr] <= elem_wdata;
      end
      elem_q_ff <= elem_mem[addr_ff];
   end

   always_ff @(posedge clock) begin
      if (hist_we) begin
         hist_mem[hist_waddr] <= hist_wdata;
      end
      hist_q_ff <= hist_mem[v_ff];
   end

   always_ff @(posedge clock) begin
      ql_ff       <= ql_in;
      qr_ff       <= qr_in;
      addr_ff     <= addr_in;
      v_ff        <= v_in;
      load_v_ff   <= load_v_in;
      prod_ff     <= prod_in;
      rsp_data_ff <= rsp_data_in;
      if (reset) begin
         state_ff     <= ST_CLEAR;
         wl_ff        <= '0;
         wr_ff        <= '0;
         empty_ff     <= 1'b1;
         sum_ff       <= '0;
         enter_ff     <= 1'b0;
         query_ff     <= 1'b0;
         phase_ff     <= 1'b0;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wl_ff        <= wl_in;
         wr_ff        <= wr_in;
         empty_ff     <= empty_in;
         sum_ff       <= sum_in;
         enter_ff     <= enter_in;
         query_ff     <= query_in;
         phase_ff     <= phase_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign clearing  = state_ff == ST_CLEAR;

endmodule

`default_nettype wire

// ===== src/window_weighted_square_count_sum.sv =====
// ----------------------------------------------------------------------------
// Window power of range queries
// Loads an array of values and answers range queries with the sum, over the
// distinct values of the window, of count squared times value.
// ----------------------------------------------------------------------------
// After reset the histogram is cleared with busy held high. A request is
// taken when start is high and busy is low; busy is high while the histogram
// is cleared or the two-entry request queue is full. A load outside the
// current window is written straight into the element store; a load inside it
// updates the histogram and the running sum first. A query moves the window
// edges one element per step, first placing one element when the window is
// empty; each step reads the element store, reads the histogram, multiplies and
// accumulates in turn; a query with left beyond right is rejected with no walk.
// Each response is shown for exactly one cycle with rsp_valid and must be
// taken then, since the receiver cannot stall the block.
`default_nettype none

`include "window_weighted_square_count_sum_macros.svh"

module window_weighted_square_count_sum
   import wwsc_pkg::*;
#(
   parameter int MAX_ELEMENTS = DEF_MAX_ELEMENTS,
   parameter int VALUE_RANGE  = DEF_VALUE_RANGE
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output logic         busy,
   input  wire req_type req_data,
   output logic         rsp_valid,
   output rsp_type      rsp_data
);

   logic          push;
   logic          pop;
   logic          q_full;
   logic          clearing;
   job_type       job;
   queue_out_type q_out;

   wwsc_front #(
      .MAX_ELEMENTS (MAX_ELEMENTS),
      .VALUE_RANGE  (VALUE_RANGE)
   ) u_front (
      .start    (start),
      .req_data (req_data),
      .q_full   (q_full),
      .clearing (clearing),
      .busy     (busy),
      .push     (push),
      .job      (job)
   );

   wwsc_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (push),
      .job_in (job),
      .pop    (pop),
      .q_out  (q_out),
      .q_full (q_full)
   );

   wwsc_back #(
      .MAX_ELEMENTS (MAX_ELEMENTS),
      .VALUE_RANGE  (VALUE_RANGE)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_out     (q_out),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .clearing  (clearing)
   );

   `WWSC_ASSERT_NEVER(a_push_full, clock, reset, push && q_full, "request pushed into full queue")
   `WWSC_ASSERT_NEVER(a_pop_empty, clock, reset, pop && !q_out.valid, "pop from empty queue")
   `WWSC_ASSERT_NEVER(a_rsp_clear, clock, reset, rsp_valid && clearing, "response during clear")
   `WWSC_ASSERT(a_reject_zero, clock, reset,
                rsp_valid && rsp_data.status |-> rsp_data.power == '0,
                "rejected query with nonzero power")

endmodule

`default_nettype wire

// ===== dv/tb_window_weighted_square_count_sum.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Window power testbench
// Loads the element array and sends range queries to the window power block.
// A model kept in the bench tracks the element array, the value histogram,
// the window edges and the running power, and predicts every response. Most
// queries slide the window by a few elements. A few queries jump far, a few
// have left beyond right, and loads land both inside and outside the window.
// Each response is checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_window_weighted_square_count_sum;
   import wwsc_pkg::*;

   localparam logic STATUS_OK        = 1'b0;
   localparam logic STATUS_BAD_RANGE = 1'b1;
   localparam int   ELEMENTS         = DEF_MAX_ELEMENTS;
   localparam int   VALUES           = DEF_VALUE_RANGE;
   localparam int   TOP_VALUE        = VALUES - 1;
   localparam int   STEP_SPAN        = 8;
   localparam int   QUIET_LIMIT      = 100000;
   localparam int   SETTLE_CYCLES    = 64;
   localparam int   REPORT_CAP       = 100;

   logic    clock    = 1'b0;
   logic    reset    = 1'b1;
   logic    start    = 1'b0;
   logic    busy;
   req_type req_data = '0;
   logic    rsp_valid;
   rsp_type rsp_data;

   req_type request_backlog[$];
   rsp_type power_answers[$];
   int      idle_pct       = 0;
   int      mismatch_count = 0;
   int      quiet_cycles   = 0;

   logic [FIELD_W-1:0] element_mem[ELEMENTS];
   int unsigned        value_count[VALUES] = '{default: 0};
   int                 win_lo              = 0;
   int                 win_hi              = 0;
   bit                 win_void            = 1'b1;
   longint unsigned    power_acc           = 0;

   int gen_lo   = 0;
   int gen_hi   = 0;
   bit gen_open = 1'b0;

   window_weighted_square_count_sum dut (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_data (rsp_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   task automatic count_in(input logic [FIELD_W-1:0] v);
      power_acc += 64'(v) * (2 * 64'(value_count[v]) + 1);
      value_count[v]++;
   endtask

   task automatic count_out(input logic [FIELD_W-1:0] v);
      if (value_count[v] != 0) begin
         value_count[v]--;
         power_acc -= 64'(v) * (2 * 64'(value_count[v]) + 1);
      end
   endtask

   task automatic predict_request(input req_type rq);
      int      lo;
      int      hi;
      rsp_type answer;
      lo = int'(rq.position);
      hi = int'(rq.right_end);
      if (rq.cmd == CMD_LOAD) begin
         if (!win_void && lo >= win_lo && lo <= win_hi) begin
            count_out(element_mem[lo]);
            count_in(rq.value);
         end
         element_mem[lo] = rq.value;
      end else if (lo > hi) begin
         answer.power  = '0;
         answer.status = STATUS_BAD_RANGE;
         power_answers.push_back(answer);
      end else begin
         if (win_void) begin
            win_lo   = lo;
            win_hi   = lo;
            win_void = 1'b0;
            count_in(element_mem[lo]);
         end
         while (win_lo > lo) begin
            win_lo--;
            count_in(element_mem[win_lo]);
         end
         while (win_hi < hi) begin
            win_hi++;
            count_in(element_mem[win_hi]);
         end
         while (win_lo < lo) begin
            count_out(element_mem[win_lo]);
            win_lo++;
         end
         while (win_hi > hi) begin
            count_out(element_mem[win_hi]);
            win_hi--;
         end
         answer.power  = (power_acc > 64'(POWER_MAX)) ? POWER_MAX : POWER_W'(power_acc);
         answer.status = STATUS_OK;
         power_answers.push_back(answer);
      end
   endtask

   task automatic report_mismatch(input string what);
      if (mismatch_count < REPORT_CAP) begin
         $display("%0t mismatch: %s", $time, what);
      end
      mismatch_count++;
   endtask

   function automatic int pick_value();
      case ($urandom_range(0, 3))
         0: return TOP_VALUE;
         1: return $urandom_range(0, 7);
         default: return $urandom_range(0, TOP_VALUE);
      endcase
   endfunction

   task automatic queue_load(input int pos, input int val);
      req_type rq;
      rq.cmd       = CMD_LOAD;
      rq.position  = FIELD_W'(pos);
      rq.right_end = FIELD_W'($urandom);
      rq.value     = FIELD_W'(val);
      request_backlog.push_back(rq);
   endtask

   task automatic queue_query(input int lo, input int hi);
      req_type rq;
      rq.cmd       = CMD_QUERY;
      rq.position  = FIELD_W'(lo);
      rq.right_end = FIELD_W'(hi);
      rq.value     = FIELD_W'($urandom);
      request_backlog.push_back(rq);
      if (lo <= hi) begin
         gen_open = 1'b1;
         gen_lo   = lo;
         gen_hi   = hi;
      end
   endtask

   // Only elements up to lim have been loaded, so valid ranges do not go beyond it.
   task automatic queue_walk(input int lim);
      int lo;
      int hi;
      int t;
      if ($urandom_range(0, 15) == 0) begin
         lo = $urandom_range(1, ELEMENTS - 1);
         queue_query(lo, $urandom_range(0, lo - 1));
      end else if (!gen_open || $urandom_range(0, 31) == 0) begin
         lo = $urandom_range(0, lim);
         hi = $urandom_range(lo, lim);
         queue_query(lo, hi);
      end else begin
         lo = gen_lo + int'($urandom_range(0, 2 * STEP_SPAN)) - STEP_SPAN;
         hi = gen_hi + int'($urandom_range(0, 2 * STEP_SPAN)) - STEP_SPAN;
         lo = (lo < 0) ? 0 : ((lo > lim) ? lim : lo);
         hi = (hi < 0) ? 0 : ((hi > lim) ? lim : hi);
         if (lo > hi) begin
            t  = lo;
            lo = hi;
            hi = t;
         end
         queue_query(lo, hi);
      end
   endtask

   task automatic queue_mix(input int count);
      repeat (count) begin
         if ($urandom_range(0, 3) == 0) begin
            queue_load($urandom_range(0, ELEMENTS - 1), pick_value());
         end else begin
            queue_walk(ELEMENTS - 1);
         end
      end
   endtask

   task automatic drain();
      @(negedge clock);
      while (request_backlog.size() != 0 || start || power_answers.size() != 0) begin
         @(negedge clock);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            predict_request(req_data);
         end
         if (!start || !busy) begin
            if (request_backlog.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
               start    <= 1'b1;
               req_data <= request_backlog.pop_front();
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (power_answers.size() == 0) begin
            report_mismatch("response with no query waiting");
         end else begin
            want = power_answers.pop_front();
            if (rsp_data.power !== want.power) begin
               report_mismatch($sformatf("power %0d, expected %0d", rsp_data.power,
                                         want.power));
            end
            if (rsp_data.status !== want.status) begin
               report_mismatch($sformatf("status %0b, expected %0b", rsp_data.status,
                                         want.status));
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles < QUIET_LIMIT) begin
         quiet_cycles <= quiet_cycles + 1;
      end else begin
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin
      int p;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      queue_query(ELEMENTS - 1, 0);
      queue_query(1, 0);
      queue_load(0, TOP_VALUE);
      queue_load(1, 0);
      queue_load(2, TOP_VALUE);
      queue_load(3, 512);
      queue_load(ELEMENTS - 1, TOP_VALUE);
      queue_query(1, 1);
      queue_query(0, 3);
      queue_load(2, 5);
      queue_load(0, TOP_VALUE);
      queue_query(0, 3);
      queue_query(2, 3);
      queue_query(3, 3);
      queue_query(5, 4);
      queue_query(3, 3);
      drain();

      idle_pct = 10;
      for (p = 4; p < ELEMENTS; p++) begin
         queue_load(p, pick_value());
         if ($urandom_range(0, 7) == 0) begin
            queue_load($urandom_range(0, p), pick_value());
         end
         if ($urandom_range(0, 3) == 0) begin
            queue_walk(p);
         end
      end
      drain();

      idle_pct = 50;
      queue_query(0, ELEMENTS - 1);
      queue_query(ELEMENTS - 1, ELEMENTS - 1);
      queue_mix(260);
      drain();

      idle_pct = 0;
      queue_mix(260);
      drain();

      repeat (SETTLE_CYCLES) @(negedge clock);
      if (mismatch_count == 0 && power_answers.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

// ===== window_weighted_square_count_sum.f =====
+incdir+src
src/wwsc_pkg.sv
src/wwsc_front.sv
src/wwsc_queue.sv
src/wwsc_back.sv
src/window_weighted_square_count_sum.sv
dv/tb_window_weighted_square_count_sum.sv
